>>> hw/rtl/gpx_pkg.sv
// ----------------------------------------------------------------------------
// GPIO expander register package
// Request and status codes, register page codes, item types and byte lane
// helpers shared by the expander register core and register file.
// ----------------------------------------------------------------------------
`default_nettype none

package gpx_pkg;

   localparam int PinWidth = 16;

   localparam logic [1:0] REQ_WRITE_START = 2'd0;
   localparam logic [1:0] REQ_WRITE_BYTE  = 2'd1;
   localparam logic [1:0] REQ_READ_BYTE   = 2'd2;
   localparam logic [1:0] REQ_PIN_EVENT   = 2'd3;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_READ_ONLY   = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

   // pointer bits [2:1] select the register page, bit 0 the byte lane
   localparam logic [1:0] PAGE_INPUT     = 2'd0;
   localparam logic [1:0] PAGE_OUTPUT    = 2'd1;
   localparam logic [1:0] PAGE_POLARITY  = 2'd2;
   localparam logic [1:0] PAGE_DIRECTION = 2'd3;

   localparam logic [7:0] UNSUPPORTED_READ = 8'hFF;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] write_byte;
      logic [3:0] pin_index;
      logic       pin_level;
   } gpx_item_type;

   typedef struct packed {
      logic [7:0]          read_data;
      logic [1:0]          status;
      logic [PinWidth-1:0] pin_drive;
   } gpx_result_type;

   function automatic logic [PinWidth-1:0] lane_write(input logic [PinWidth-1:0] word,
                                                      input logic hi,
                                                      input logic [7:0] data);
      logic [PinWidth-1:0] res;
      res = word;
      if (hi) begin
         res[15:8] = data;
      end else begin
         res[7:0] = data;
      end
      return res;
   endfunction

   function automatic logic [7:0] lane_read(input logic [PinWidth-1:0] word,
                                            input logic hi);
      return hi ? word[15:8] : word[7:0];
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/i2c_gpio_expander_registers_core.sv
// ----------------------------------------------------------------------------
// GPIO expander register core
// Register file of a 16-pin bus GPIO expander: pointer capture, byte lane
// writes of output, polarity and direction, reads of those and input, and pin level events.
//
//   channel | ports                                          | direction
//   req     | req_valid req_ready req_type req_write_byte    | in
//           | req_pin_index req_pin_level                    |
//   rsp     | rsp_valid rsp_ready rsp_read_data rsp_status   | out
//           | rsp_pin_drive                                  |
//
// One item per cycle while rsp is not stalled; each item passes through the
// input register and then the result register.
// Reset clears pointer, levels and polarity, sets output and direction high.
// A stalled rsp holds the result register; the input register takes one more
// item, then req waits until the held result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_gpio_expander_registers_core
   import gpx_pkg::*;
#(
   parameter int PIN_COUNT = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_type,
   input  wire logic [7:0]          req_write_byte,
   input  wire logic [3:0]          req_pin_index,
   input  wire logic                req_pin_level,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_read_data,
   output logic [1:0]               rsp_status,
   output logic [PinWidth-1:0]      rsp_pin_drive
);

   logic           item_valid_ff, item_valid_in;
   gpx_item_type   item_ff;
   logic           rsp_valid_ff,  rsp_valid_in;
   gpx_result_type rsp_ff;
   gpx_result_type result;
   logic           out_free;
   logic           item_fire;
   logic           req_fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign item_fire = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign item_valid_in = req_fire || (item_valid_ff && !item_fire);
   assign rsp_valid_in  = item_fire || (rsp_valid_ff && !rsp_ready);

   gpx_regs #(
      .PIN_COUNT (PIN_COUNT)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .item_fire (item_fire),
      .item      (item_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.kind       <= req_type;
         item_ff.write_byte <= req_write_byte;
         item_ff.pin_index  <= req_pin_index;
         item_ff.pin_level  <= req_pin_level;
      end
      if (item_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_status    = rsp_ff.status;
   assign rsp_pin_drive = rsp_ff.pin_drive;

endmodule

`default_nettype wire

>>> hw/rtl/gpx_regs.sv
// ----------------------------------------------------------------------------
// GPIO expander register file
// Holds pointer, latches and pin levels; while item_fire is high, decodes
// one item per cycle into the next register state and its result.
// ----------------------------------------------------------------------------
`default_nettype none

module gpx_regs
   import gpx_pkg::*;
#(
   parameter int PIN_COUNT = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           item_fire,
   input  wire gpx_item_type   item,
   output gpx_result_type      result
);

   localparam logic [PinWidth-1:0] PinMask = PinWidth'((33'd1 << PIN_COUNT) - 33'd1);

   logic [7:0]          pointer_ff,   pointer_in;
   logic                pending_ff,   pending_in;
   logic [PinWidth-1:0] output_ff,    output_in;
   logic [PinWidth-1:0] polarity_ff,  polarity_in;
   logic [PinWidth-1:0] direction_ff, direction_in;
   logic [PinWidth-1:0] input_ff,     input_in;
   logic [PinWidth-1:0] driven_ff,    driven_in;

   logic                hi;
   logic                page_ok;
   logic [1:0]          page;
   logic [PinWidth-1:0] out_mask;

   assign hi      = pointer_ff[0];
   assign page    = pointer_ff[2:1];
   assign page_ok = (pointer_ff[7:3] == 5'd0);

   always_comb begin
      pointer_in       = pointer_ff;
      pending_in       = pending_ff;
      output_in        = output_ff;
      polarity_in      = polarity_ff;
      direction_in     = direction_ff;
      input_in         = input_ff;
      result.read_data = 8'd0;
      result.status    = STATUS_OK;
      unique case (item.kind)
         REQ_WRITE_START: begin
            pending_in = 1'b1;
         end
         REQ_WRITE_BYTE: begin
            if (pending_ff) begin
               pointer_in = item.write_byte;
               pending_in = 1'b0;
            end else if (!page_ok) begin
               result.status = STATUS_UNSUPPORTED;
            end else begin
               unique case (page)
                  PAGE_INPUT:     result.status = STATUS_READ_ONLY;
                  PAGE_OUTPUT:    output_in    = lane_write(output_ff, hi, item.write_byte);
                  PAGE_POLARITY:  polarity_in  = lane_write(polarity_ff, hi, item.write_byte);
                  PAGE_DIRECTION: direction_in = lane_write(direction_ff, hi, item.write_byte);
                  default:        result.status = STATUS_UNSUPPORTED;
               endcase
            end
         end
         REQ_READ_BYTE: begin
            if (!page_ok) begin
               result.read_data = UNSUPPORTED_READ;
               result.status    = STATUS_UNSUPPORTED;
            end else begin
               unique case (page)
                  PAGE_INPUT:     result.read_data = lane_read(input_ff, hi);
                  PAGE_OUTPUT:    result.read_data = lane_read(output_ff, hi);
                  PAGE_POLARITY:  result.read_data = lane_read(polarity_ff, hi);
                  PAGE_DIRECTION: result.read_data = lane_read(direction_ff, hi);
                  default:        result.read_data = UNSUPPORTED_READ;
               endcase
            end
         end
         REQ_PIN_EVENT: begin
            if (32'(item.pin_index) < PIN_COUNT) begin
               input_in[item.pin_index] = item.pin_level;
            end
            input_in = input_in & PinMask;
         end
         default: begin
            pending_in = pending_ff;
         end
      endcase
      out_mask         = ~direction_in & PinMask;
      driven_in        = ((driven_ff & ~out_mask) | (output_in & out_mask)) & PinMask;
      result.pin_drive = driven_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff   <= 8'd0;
         pending_ff   <= 1'b0;
         output_ff    <= '1;
         polarity_ff  <= '0;
         direction_ff <= '1;
         input_ff     <= '0;
         driven_ff    <= '0;
      end else if (item_fire) begin
         pointer_ff   <= pointer_in;
         pending_ff   <= pending_in;
         output_ff    <= output_in;
         polarity_ff  <= polarity_in;
         direction_ff <= direction_in;
         input_ff     <= input_in;
         driven_ff    <= driven_in;
      end
   end

endmodule

`default_nettype wire
